>>> hdl/assert_macros.svh
// Assertion macros for the dense layer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define DLF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define DLF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DLF_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLF_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hdl/dlf_pkg.sv
// Package: payload types, codes and activation tables of the dense layer.
`timescale 1ns / 1ps
`default_nettype none

package dlf_pkg;

    // Command codes
    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_VALUE   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS  = 2'd2;

    // Activation modes
    localparam logic [1:0] ACT_RELU    = 2'd0;
    localparam logic [1:0] ACT_TANH    = 2'd1;
    localparam logic [1:0] ACT_SIGMOID = 2'd2;

    // Register reset values
    localparam logic [1:0] ACT_MODE_RESET = ACT_RELU;
    localparam logic [5:0] INPUTS_RESET   = 6'd32;
    localparam logic [4:0] OUTPUTS_RESET  = 5'd16;

    // Q4.12 fixed point
    localparam int Q12_FRAC   = 12;
    localparam int ROUND_HALF = 2048;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         in_index;
        logic [3:0]         out_index;
        logic signed [15:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         neuron_index;
        logic signed [15:0] activation;
        logic               last;
    } t_out_item;

    typedef logic [255:0][15:0] t_lut;

    localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
    localparam int          EXP_COUNT = 257;

    // (a*b) >> 60 on Q60 operands, built from 32-bit limbs
    function automatic logic [63:0] lut_mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 32;
        al = {32'd0, a[31:0]};
        bh = b >> 32;
        bl = {32'd0, b[31:0]};
        return ah * bh * 64'd16 + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // Shift-subtract quotient, elaboration time only
    function automatic logic [63:0] lut_div_small(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 4096*num/den rounded half up, num < den
    function automatic logic [15:0] lut_ratio_q12(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          b;
        rem = num;
        quo = '0;
        for (b = 0; b < 13; b++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return 16'((quo + 64'd1) >> 1);
    endfunction

    // Tanh or sigmoid table over [-8, 8) in steps of 1/16, lower step edge
    function automatic t_lut build_lut(input logic is_sigmoid);
        logic [63:0] ex [EXP_COUNT];
        logic [63:0] e1;
        logic [63:0] term;
        logic [15:0] t;
        t_lut        lut;
        int          n, i, k, m;
        e1   = ONE_Q60;
        term = ONE_Q60;
        // exp(-1/16) by its series
        for (n = 1; n <= 20; n++) begin
            term = lut_div_small(term, 64'(16 * n));
            if (n[0])
                e1 = e1 - term;
            else
                e1 = e1 + term;
        end
        ex[0] = ONE_Q60;
        for (n = 1; n < EXP_COUNT; n++) begin
            ex[n] = lut_mul_q60(ex[n-1], e1);
        end
        for (i = 0; i < 256; i++) begin
            k = i - 128;
            m = (k < 0) ? -k : k;
            if (!is_sigmoid) begin
                t      = lut_ratio_q12(ONE_Q60 - ex[2*m], ONE_Q60 + ex[2*m]);
                lut[i] = (k < 0) ? 16'd0 - t : t;
            end else if (k >= 0) begin
                lut[i] = lut_ratio_q12(ONE_Q60, ONE_Q60 + ex[m]);
            end else begin
                lut[i] = lut_ratio_q12(ex[m], ONE_Q60 + ex[m]);
            end
        end
        return lut;
    endfunction

    localparam t_lut TANH_LUT = build_lut(1'b0);
    localparam t_lut SIGM_LUT = build_lut(1'b1);

endpackage

`default_nettype wire

>>> hdl/dense_layer_forward_unit.sv
// Dense layer forward unit: weight/value memories, MAC sequencer, output register.
// Weight and value writes: one per cycle, stall low while idle.
// Compute: the single MAC walks the weight memory one entry per cycle while issuing,
// column by column; each sum then waits in drain until the output register is free.
// Sync active-low reset restores config defaults, clears input valid bits and control; weights stay.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dense_layer_forward_unit #(
    parameter int MAX_INPUTS  = 32,
    parameter int MAX_OUTPUTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dlf_pkg::t_in_item                i_in_item,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dlf_pkg::t_out_item               o_out_item,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dlf_pkg::*;

    // Weight memory: row = input (bias row last), column = output neuron
    localparam int W_DEPTH = (MAX_INPUTS + 1) * MAX_OUTPUTS;
    localparam int WAW     = $clog2(W_DEPTH);
    localparam int XAW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int TW      = $clog2(MAX_INPUTS + 1);   // term counter, bias included
    localparam int OW      = $clog2(MAX_OUTPUTS + 1);  // column counter / count
    localparam int PROD_W  = 32;
    localparam int ACC_W   = PROD_W + TW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,   // one memory read per cycle, one term each
        ST_DRAIN    // wait for the sum to leave the MAC pipe and the output register to be free
    } t_state;

    t_state r_state;

    // configuration registers
    logic [1:0] r_act_mode;
    logic [5:0] r_inputs_in_use;
    logic [4:0] r_outputs_in_use;

    // run control
    logic [TW-1:0] r_term;
    logic [OW-1:0] r_col;
    logic [TW-1:0] r_n_in;
    logic [OW-1:0] r_n_out;

    // memories
    logic signed [15:0]    r_weight_mem [W_DEPTH];
    logic signed [15:0]    r_x_mem      [MAX_INPUTS];
    logic [MAX_INPUTS-1:0] r_x_valid;

    // MAC pipe: read stage, product stage, accumulator
    logic               r_s1_vld, r_s1_first, r_s1_bias;
    logic signed [15:0] r_w_rdata, r_x_rdata;
    logic               r_x_ok;
    logic               r_s2_vld, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic               r_acc_done;

    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_xfer;
    logic               w_wr, x_wr;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic [XAW-1:0]     x_waddr, x_raddr;
    logic [TW-1:0]      sat_inputs, w_row;
    logic [OW-1:0]      sat_outputs;
    logic               rd_en, x_rd, term_is_bias;
    logic signed [15:0] x_eff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [15:0] act_value;
    logic               out_free, out_load, col_last, start_run;

    // ---------------- handshakes ----------------
    // Memories are single-ported per side: no item is taken while a run reads them.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Counts saturate at the built array sizes
    assign sat_inputs  = (r_inputs_in_use > 6'(MAX_INPUTS)) ? TW'(MAX_INPUTS)
                                                           : TW'(r_inputs_in_use);
    assign sat_outputs = ({2'b00, r_outputs_in_use} > 7'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS)
                                                                      : OW'(r_outputs_in_use);

    // ---------------- write decode ----------------
    // Out-of-range weight or value writes are dropped; bias input stays 1.0.
    assign w_wr    = in_xfer && (i_in_item.command == CMD_WEIGHT)
                  && (i_in_item.in_index <= 6'(MAX_INPUTS))
                  && ({3'b000, i_in_item.out_index} < 7'(MAX_OUTPUTS));
    assign w_waddr = WAW'(i_in_item.in_index) * WAW'(MAX_OUTPUTS) + WAW'(i_in_item.out_index);
    assign x_wr    = in_xfer && (i_in_item.command == CMD_VALUE)
                  && (i_in_item.in_index < 6'(MAX_INPUTS));
    assign x_waddr = XAW'(i_in_item.in_index);

    assign start_run = in_xfer && (i_in_item.command == CMD_COMPUTE) && (sat_outputs != '0);

    // ---------------- read side ----------------
    // Terms 0..n_in-1 are inputs, term n_in is the bias row (input fixed at 1.0).
    assign rd_en        = (r_state == ST_ISSUE);
    assign term_is_bias = (r_term == r_n_in);
    assign x_rd         = rd_en && !term_is_bias;
    assign w_row        = term_is_bias ? TW'(MAX_INPUTS) : r_term;
    assign w_raddr      = WAW'(w_row) * WAW'(MAX_OUTPUTS) + WAW'(r_col);
    assign x_raddr      = r_term[XAW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr)
            r_weight_mem[w_waddr] <= i_in_item.data_value;
        if (rd_en)
            r_w_rdata <= r_weight_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (x_wr)
            r_x_mem[x_waddr] <= i_in_item.data_value;
        if (x_rd) begin
            r_x_rdata <= r_x_mem[x_raddr];
            r_x_ok    <= r_x_valid[x_raddr];
        end
    end

    // ---------------- MAC pipe ----------------
    // Unwritten input values read as zero through their valid bits.
    assign x_eff  = r_x_ok ? r_x_rdata : 16'sd0;
    assign n_prod = r_s1_bias ? (PROD_W'(r_w_rdata) <<< Q12_FRAC)
                              : PROD_W'(x_eff) * PROD_W'(r_w_rdata);
    assign n_acc  = (r_s2_first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld <= rd_en;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld && r_s2_last)
                r_acc_done <= 1'b1;
            else if (out_load)
                r_acc_done <= 1'b0;
        end
        r_s1_first <= (r_term == '0);
        r_s1_bias  <= term_is_bias;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_bias;
        r_prod     <= n_prod;
        if (r_s2_vld)
            r_acc <= n_acc;
    end

    dlf_post #(
        .ACC_W (ACC_W)
    ) u_post (
        .i_acc  (r_acc),
        .i_mode (r_act_mode),
        .o_act  (act_value)
    );

    // ---------------- result stage ----------------
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == ST_DRAIN) && r_acc_done && out_free;
    assign col_last = ((r_col + OW'(1)) == r_n_out);

    // config and value valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode       <= ACT_MODE_RESET;
            r_inputs_in_use  <= INPUTS_RESET;
            r_outputs_in_use <= OUTPUTS_RESET;
            r_x_valid        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACT_MODE: r_act_mode       <= i_cfg_data[1:0];
                    CFG_INPUTS:   r_inputs_in_use  <= i_cfg_data[5:0];
                    CFG_OUTPUTS:  r_outputs_in_use <= i_cfg_data[4:0];
                    default:      ;
                endcase
            end
            if (x_wr)
                r_x_valid[x_waddr] <= 1'b1;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= '0;
            r_col       <= '0;
            r_n_in      <= '0;
            r_n_out     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (start_run) begin
                        r_n_in  <= sat_inputs;
                        r_n_out <= sat_outputs;
                        r_term  <= '0;
                        r_col   <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (term_is_bias) begin
                        r_term  <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_term <= r_term + TW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        if (col_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_col   <= r_col + OW'(1);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        if (out_load) begin
            r_out_item.neuron_index <= 4'(r_col);
            r_out_item.activation   <= act_value;
            r_out_item.last         <= col_last;
        end
    end

    // ---------------- assertions ----------------
    `DLF_ASSERT(a_done_in_drain, i_clk, i_rst_n, r_acc_done |-> (r_state == ST_DRAIN), "sum ready outside drain")
    `DLF_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n, (r_state == ST_IDLE) |-> (!r_s1_vld && !r_s2_vld && !r_acc_done), "MAC pipe busy while idle")
    `DLF_ASSERT(a_col_in_range, i_clk, i_rst_n, (r_state != ST_IDLE) |-> (r_col < r_n_out), "column past output count")
    `DLF_NEVER(a_sum_overrun, i_clk, i_rst_n, r_s2_vld && r_acc_done, "new term while sum pending")

endmodule

`default_nettype wire

>>> hdl/dlf_post.sv
// Round, saturate and activate one accumulated neuron sum.
`timescale 1ns / 1ps
`default_nettype none

module dlf_post #(
    parameter int ACC_W = 38
) (
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic [1:0]              i_mode,
    output logic signed [15:0]      o_act
);
    import dlf_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAT_MIN);

    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] scaled;
    logic signed [15:0]      q;
    logic [7:0]              lut_idx;

    always_comb begin
        rounded = i_acc + ACC_W'(ROUND_HALF);
        scaled  = rounded >>> Q12_FRAC;          // floor toward minus infinity
        if (scaled > SAT_HI)
            q = 16'(SAT_MAX);
        else if (scaled < SAT_LO)
            q = 16'(SAT_MIN);
        else
            q = scaled[15:0];
        // (q + 8.0) in 1/16 steps
        lut_idx = {~q[15], q[14:8]};
        case (i_mode)
            ACT_TANH:    o_act = $signed(TANH_LUT[lut_idx]);
            ACT_SIGMOID: o_act = $signed(SIGM_LUT[lut_idx]);
            default:     o_act = (q > 16'sd0) ? q : 16'sd0;
        endcase
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the dense layer forward unit.
`timescale 1ns / 1ps

module testbench;
    import dlf_pkg::*;

    // Sizes match the default build of the unit
    localparam int MAX_INPUTS  = 32;
    localparam int MAX_OUTPUTS = 16;
    localparam int BIAS_ROW    = MAX_INPUTS;

    // Codes the package leaves unnamed: both are accepted and act as no-ops or ReLU
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // Settle time runs a bit past the worst compute run
    localparam int SETTLE_CYCLES  = MAX_OUTPUTS * (MAX_INPUTS + 4) + 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;

    // Clock, reset and block-side signals
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      o_cfg_ready;

    // Stimulus queue and the results still owed by the unit
    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    // Shadow of the layer: weights, input activations and register file
    logic signed [15:0] wt_model  [0:MAX_INPUTS][0:MAX_OUTPUTS-1];
    logic signed [15:0] val_model [0:MAX_INPUTS-1];
    logic [1:0]         cur_act     = ACT_MODE_RESET;
    logic [5:0]         cur_inputs  = INPUTS_RESET;
    logic [4:0]         cur_outputs = OUTPUTS_RESET;

    // Activation tables, indexed by the saturated sum in 1/16 steps
    logic signed [15:0] tanh_tab [0:255];
    logic signed [15:0] sigm_tab [0:255];

    // Which weights the stimulus has written so far (never read an unwritten one)
    bit wt_known [0:MAX_INPUTS][0:MAX_OUTPUTS-1];

    // Idling knobs, changed by the sequencer between phases
    int send_pct = 0;
    int recv_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    int error_count    = 0;
    int transfers_in   = 0;
    int compute_runs   = 0;
    int results_seen   = 0;
    int settings_seen  = 0;

    dense_layer_forward_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Activation table construction (Q60 exact arithmetic)
    // ------------------------------------------------------------------

    // (a * b) >> 60 for Q60 operands up to 1.0, split in 32-bit halves
    function automatic logic [63:0] fix60_product(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 32;
        al = a & 64'hFFFF_FFFF;
        bh = b >> 32;
        bl = b & 64'hFFFF_FFFF;
        return ah * bh * 64'd16 + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // 4096 * num / den, rounded half up; num < den
    function automatic logic [15:0] q12_fraction(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem, quo;
        int          b;
        rem = num;
        quo = '0;
        for (b = 0; b < 13; b++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return 16'((quo + 64'd1) >> 1);
    endfunction

    task automatic fill_activation_tables();
        logic [63:0] pw [0:256];
        logic [63:0] step, term;
        logic [15:0] t;
        int          n, i, k, m;
        // e^(-1/16) from its alternating series
        step = Q60_ONE;
        term = Q60_ONE;
        for (n = 1; n <= 20; n++) begin
            term = term / 64'(16 * n);
            if (n % 2 == 1) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        // pw[n] = e^(-n/16)
        pw[0] = Q60_ONE;
        for (n = 1; n <= 256; n++) begin
            pw[n] = fix60_product(pw[n-1], step);
        end
        for (i = 0; i < 256; i++) begin
            k = i - 128;
            m = (k < 0) ? -k : k;
            t = q12_fraction(Q60_ONE - pw[2*m], Q60_ONE + pw[2*m]);
            tanh_tab[i] = (k < 0) ? 16'd0 - t : t;
            if (k >= 0) begin
                sigm_tab[i] = q12_fraction(Q60_ONE, Q60_ONE + pw[m]);
            end else begin
                sigm_tab[i] = q12_fraction(pw[m], Q60_ONE + pw[m]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Layer prediction
    // ------------------------------------------------------------------

    function automatic int active_inputs();
        return (cur_inputs > MAX_INPUTS) ? MAX_INPUTS : int'(cur_inputs);
    endfunction

    function automatic int active_outputs();
        return (cur_outputs > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(cur_outputs);
    endfunction

    // Exact dot product plus bias, rounded half up and clamped to Q4.12
    function automatic logic signed [15:0] neuron_level(input int col, input int n_in);
        logic signed [63:0] acc;
        int                 i;
        acc = wt_model[BIAS_ROW][col];
        acc = acc * 64'sd4096;
        for (i = 0; i < n_in; i++) begin
            acc = acc + val_model[i] * wt_model[i][col];
        end
        // floor((acc + half) / 4096)
        acc = (acc + 64'sd2048) >>> Q12_FRAC;
        if (acc > 64'sd32767) begin
            acc = 64'sd32767;
        end else if (acc < -64'sd32768) begin
            acc = -64'sd32768;
        end
        return 16'(acc);
    endfunction

    // Apply one accepted item to the shadow layer and queue what it must produce
    task automatic predict_transfer(input t_in_item it);
        t_out_item          r;
        logic signed [15:0] level;
        logic signed [15:0] act;
        logic [15:0]        offs;
        int                 n_in, n_out, j;
        n_in  = active_inputs();
        n_out = active_outputs();
        transfers_in++;
        case (it.command)
            CMD_WEIGHT: begin
                if (it.in_index <= MAX_INPUTS && it.out_index < MAX_OUTPUTS) begin
                    wt_model[it.in_index][it.out_index] = it.data_value;
                end
            end
            CMD_VALUE: begin
                // the bias input is fixed at 1.0, so its index is dropped
                if (it.in_index < MAX_INPUTS) begin
                    val_model[it.in_index] = it.data_value;
                end
            end
            CMD_COMPUTE: begin
                compute_runs++;
                for (j = 0; j < n_out; j++) begin
                    level = neuron_level(j, n_in);
                    // offset binary: top byte is the table step over [-8, 8)
                    offs = level ^ 16'h8000;
                    case (cur_act)
                        ACT_TANH:    act = tanh_tab[offs[15:8]];
                        ACT_SIGMOID: act = sigm_tab[offs[15:8]];
                        default:     act = (level > 0) ? level : 16'sd0;
                    endcase
                    r.neuron_index = 4'(j);
                    r.activation   = act;
                    r.last         = (j == n_out - 1);
                    expected_results = {expected_results, r};
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result: neuron %0d activation %0d last %0b",
                                    got.neuron_index, got.activation, got.last));
        end else begin
            want = expected_results.pop_front();
            if (got.neuron_index !== want.neuron_index) begin
                note_mismatch($sformatf("neuron_index got %0d want %0d",
                                        got.neuron_index, want.neuron_index));
            end
            if (got.activation !== want.activation) begin
                note_mismatch($sformatf("neuron %0d activation got %0d want %0d",
                                        want.neuron_index, got.activation, want.activation));
            end
            if (got.last !== want.last) begin
                note_mismatch($sformatf("neuron %0d last got %0b want %0b",
                                        want.neuron_index, got.last, want.last));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, now and then long
    // ------------------------------------------------------------------

    function automatic int idle_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, holds them while the unit stalls
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!(in_valid && o_in_stall)) begin
            // previous item (if any) transferred at this edge
            if (in_valid) begin
                predict_transfer(in_item);
            end
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() != 0) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                gap_left <= ($urandom_range(0, 99) < send_pct) ? idle_length() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer, drives random and long stalls
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_result(o_out_item);
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                // one long back-pressure stretch so the unit fills and stalls its input
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (stall_left > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 99) < recv_pct) begin
                out_stall  <= 1'b1;
                stall_left <= idle_length() - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer on any channel ends the run
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                     (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT @%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [15:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom);
            // mostly within +-1.0 so tanh and sigmoid see their steep region
            default: return 16'($urandom_range(0, 8192)) - 16'd4096;
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] cmd, input logic [5:0] ii,
                              input logic [3:0] oi, input logic [15:0] val);
        t_in_item it;
        it.command    = cmd;
        it.in_index   = ii;
        it.out_index  = oi;
        it.data_value = val;
        pending_items = {pending_items, it};
        if (cmd == CMD_WEIGHT && ii <= MAX_INPUTS) begin
            wt_known[ii][oi] = 1'b1;
        end
    endtask

    // Write any weight the next compute would read that was never written
    task automatic cover_weights();
        int r, c, n_in, n_out;
        n_in  = active_inputs();
        n_out = active_outputs();
        for (c = 0; c < n_out; c++) begin
            for (r = 0; r <= MAX_INPUTS; r++) begin
                if ((r < n_in || r == BIAS_ROW) && !wt_known[r][c]) begin
                    queue_item(CMD_WEIGHT, 6'(r), 4'(c), pick_data());
                end
            end
        end
    endtask

    // Well-formed load/compute sequences with random content, plus some noise;
    // the budget counts every queued item
    task automatic random_mix(input int budget);
        int start, sel, k, n_in;
        start = pending_items.size();
        n_in  = active_inputs();
        while (pending_items.size() < start + budget) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // ignored traffic: spare command and out-of-range indexes
                case ($urandom_range(0, 2))
                    0: queue_item(CMD_SPARE, 6'($urandom), 4'($urandom), 16'($urandom));
                    1: queue_item(CMD_WEIGHT, 6'($urandom_range(33, 63)), 4'($urandom),
                                  pick_data());
                    default: queue_item(CMD_VALUE, 6'($urandom_range(MAX_INPUTS, 63)),
                                        4'($urandom), pick_data());
                endcase
            end else if (sel <= 2) begin
                queue_item(CMD_WEIGHT, 6'($urandom_range(0, MAX_INPUTS)),
                           4'($urandom_range(0, MAX_OUTPUTS - 1)), pick_data());
            end else if (sel <= 5) begin
                for (k = $urandom_range(1, 3); k > 0; k--) begin
                    if (n_in > 0 && $urandom_range(0, 3) != 0) begin
                        queue_item(CMD_VALUE, 6'($urandom_range(0, n_in - 1)),
                                   4'($urandom), pick_data());
                    end else begin
                        queue_item(CMD_VALUE, 6'($urandom_range(0, MAX_INPUTS - 1)),
                                   4'($urandom), pick_data());
                    end
                end
            end else begin
                cover_weights();
                // unused fields of a compute still carry random bits
                queue_item(CMD_COMPUTE, 6'($urandom), 4'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACT_MODE: cur_act     = data[1:0];
            CFG_INPUTS:   cur_inputs  = data[5:0];
            CFG_OUTPUTS:  cur_outputs = data[4:0];
            default: ;
        endcase
    endtask

    // New register setting plus idling knobs for the phase that follows
    task automatic set_layer(input logic [1:0] act, input int ins, input int outs,
                             input int sp, input int rp);
        write_reg(CFG_ACT_MODE, CFG_DATA_W'(act));
        write_reg(CFG_INPUTS, CFG_DATA_W'(ins));
        write_reg(CFG_OUTPUTS, CFG_DATA_W'(outs));
        @(negedge clk);
        send_pct = sp;
        recv_pct = rp;
        settings_seen++;
    endtask

    // Every queued item sent and every owed result received
    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Drained, then a settle time past the worst compute run
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial begin
        fill_activation_tables();
        for (int i = 0; i < MAX_INPUTS; i++) begin
            val_model[i] = '0;
        end
        for (int r = 0; r <= MAX_INPUTS; r++) begin
            for (int c = 0; c < MAX_OUTPUTS; c++) begin
                wt_model[r][c] = '0;
                wt_known[r][c] = 1'b0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, saturation, rounding, ignored items
        set_layer(ACT_RELU, 2, 2, 0, 0);
        @(negedge clk);
        queue_item(CMD_WEIGHT, 6'd0, 4'd0, 16'h7FFF);
        queue_item(CMD_WEIGHT, 6'd1, 4'd0, 16'h8000);
        queue_item(CMD_WEIGHT, 6'(BIAS_ROW), 4'd0, 16'h7FFF);
        queue_item(CMD_WEIGHT, 6'd0, 4'd1, 16'h1000);
        queue_item(CMD_WEIGHT, 6'd1, 4'd1, 16'hF000);
        queue_item(CMD_WEIGHT, 6'(BIAS_ROW), 4'd1, 16'h8000);
        // inputs still hold their reset zeros: bias only
        queue_item(CMD_COMPUTE, 6'd0, 4'd0, 16'h0000);
        queue_item(CMD_VALUE, 6'd0, 4'd0, 16'h7FFF);
        queue_item(CMD_VALUE, 6'd1, 4'd0, 16'h8000);
        queue_item(CMD_COMPUTE, 6'd63, 4'd15, 16'hFFFF);
        // bias input cannot be overwritten; out-of-range writes and spare command drop
        queue_item(CMD_VALUE, 6'(BIAS_ROW), 4'd0, 16'h7FFF);
        queue_item(CMD_VALUE, 6'd63, 4'd15, 16'h1234);
        queue_item(CMD_WEIGHT, 6'd33, 4'd5, 16'h7FFF);
        queue_item(CMD_WEIGHT, 6'd63, 4'd15, 16'h8000);
        queue_item(CMD_SPARE, 6'd63, 4'd15, 16'hFFFF);
        queue_item(CMD_COMPUTE, 6'd0, 4'd0, 16'h0000);
        // exact half LSB in one column, rounds up
        queue_item(CMD_WEIGHT, 6'd0, 4'd1, 16'h0800);
        queue_item(CMD_WEIGHT, 6'd1, 4'd1, 16'h0000);
        queue_item(CMD_WEIGHT, 6'(BIAS_ROW), 4'd1, 16'h0000);
        queue_item(CMD_VALUE, 6'd0, 4'd0, 16'h0001);
        queue_item(CMD_VALUE, 6'd1, 4'd0, 16'hFFFF);
        queue_item(CMD_COMPUTE, 6'd0, 4'd0, 16'h0000);
        wait_idle();

        // Random phases across activation modes and count extremes
        set_layer(ACT_TANH, 4, 3, 30, 30);
        random_mix(40);
        wait_idle();

        // widest output: long receiver hold while items keep coming
        set_layer(ACT_SIGMOID, 1, MAX_OUTPUTS, 20, 10);
        hold_req = 1'b1;
        random_mix(50);
        wait_idle();

        set_layer(ACT_SPARE, MAX_INPUTS, 1, 25, 25);
        random_mix(60);
        wait_idle();

        // no inputs summed (bias alone), output count above the maximum
        set_layer(ACT_RELU, 0, 31, 25, 25);
        random_mix(30);
        wait_idle();

        // input count above the maximum
        set_layer(ACT_TANH, 63, 2, 25, 40);
        random_mix(40);
        wait_idle();

        // zero outputs: computes produce nothing
        set_layer(ACT_SIGMOID, 8, 0, 25, 25);
        random_mix(20);
        wait_idle();

        // back-to-back with no idling, sender stops midway until all results are in
        set_layer(ACT_TANH, 6, 5, 0, 0);
        random_mix(30);
        wait_drained();
        random_mix(30);
        wait_idle();

        set_layer(ACT_RELU, 3, 4, 40, 30);
        random_mix(40);
        wait_idle();

        if (expected_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Covered %0d input transfers with %0d compute runs, %0d results checked,",
                 transfers_in, compute_runs, results_seen);
        $display("over %0d register settings: all activations, counts 0 to max and beyond.",
                 settings_seen);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
